[rtl/sawtc_pkg.sv]
`timescale 1ns / 1ps

package sawtc_pkg;

   localparam int LINE_SHIFT = 6;
   localparam int LINE_BYTES = 64;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new request
      logic part_setup;  // select part two of a split access
      logic tag_rd;      // issue tag lookup for the current part
      logic resolve;     // evaluate hit and choose a victim
      logic byte_op;     // perform one byte read or write step
      logic fill_step;   // move one byte from memory into the victim line
      logic fill_done;   // install tag and valid for the victim line
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic zero_len;
      logic is_write;
      logic hit;
      logic bytes_done;
      logic fill_last;
      logic need_second;
      logic on_second;
      logic clear_done;
   } sts_type;

endpackage

[rtl/sawtc_ctrl.sv]
`timescale 1ns / 1ps

module sawtc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  sawtc_pkg::sts_type sts,
   output sawtc_pkg::ctl_type ctl
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_LOOKUP  = 4'd2;
   localparam logic [3:0] S_RESOLVE = 4'd3;
   localparam logic [3:0] S_FILL    = 4'd4;
   localparam logic [3:0] S_FILLEND = 4'd5;
   localparam logic [3:0] S_BYTES   = 4'd6;
   localparam logic [3:0] S_NEXT    = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (sts.zero_len) begin
               state_in   = S_RESP;
            end else begin
               ctl.tag_rd = 1'b1;
               state_in   = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            ctl.resolve = 1'b1;
            if (sts.hit || sts.is_write) begin
               state_in = S_BYTES;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            ctl.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = S_FILLEND;
            end
         end
         S_FILLEND: begin
            ctl.fill_done = 1'b1;
            state_in      = S_BYTES;
         end
         S_BYTES: begin
            ctl.byte_op = 1'b1;
            if (sts.bytes_done) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (sts.need_second && !sts.on_second) begin
               ctl.part_setup = 1'b1;
               state_in       = S_LOOKUP;
            end else begin
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/sawtc_dp.sv]
`timescale 1ns / 1ps

module sawtc_dp #(
   parameter int WAYS          = 8,
   parameter int NUM_LINES     = 1024,
   parameter int MEM_ADDR_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [55:0]        req_tdata,
   input  sawtc_pkg::ctl_type ctl,
   output sawtc_pkg::sts_type sts,
   output logic [39:0]        rsp_tdata
);

   localparam int NUM_SETS   = NUM_LINES / WAYS;
   localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_BITS  = $clog2(NUM_LINES);
   localparam int OFF_BITS   = sawtc_pkg::LINE_SHIFT;
   localparam int BLK_BITS   = MEM_ADDR_BITS - OFF_BITS;
   localparam int TAG_BITS   = (BLK_BITS - SET_BITS > 0) ? BLK_BITS - SET_BITS : 1;
   localparam int ENTRY_BITS = TAG_BITS + 1;
   localparam int MEM_DEPTH  = 1 << MEM_ADDR_BITS;
   localparam int DATA_BITS  = LINE_BITS + OFF_BITS;

   // Request fields.
   logic                     cmd_ff;
   logic [MEM_ADDR_BITS-1:0] addr_ff;
   logic [2:0]               len_ff;
   logic [31:0]              wdata_ff;

   // Per-part working state.
   logic [MEM_ADDR_BITS-1:0] paddr_ff;
   logic [2:0]               pcnt_ff;   // bytes in the current part
   logic [2:0]               bidx_ff;   // byte index within the whole access
   logic [2:0]               pstart_ff; // first byte index of the current part
   logic                     second_ff;
   logic [31:0]              rdata_ff;
   logic                     hit1_ff, hit2_ff, span_ff;
   logic                     hit_ff;
   logic [WAY_BITS-1:0]      way_ff;
   logic [OFF_BITS:0]        fcnt_ff;
   logic [15:0]              lfsr_ff;
   logic                     rd_pend_ff;
   logic [2:0]               rd_idx_ff;

   // Storage. Each set word holds one {valid, tag} entry per way, way 0 lowest.
   logic [WAYS*ENTRY_BITS-1:0] set_mem  [NUM_SETS];
   logic [7:0]                 data_mem [NUM_LINES * sawtc_pkg::LINE_BYTES];
   logic [7:0]                 bk_mem   [MEM_DEPTH];
   logic [WAYS*ENTRY_BITS-1:0] set_q_ff;
   logic [WAYS*ENTRY_BITS-1:0] set_wr;
   logic [7:0]                 data_q_ff;
   logic [7:0]                 bk_q_ff;

   // Memory clearing after reset.
   logic [MEM_ADDR_BITS:0] clr_ff;
   logic                   clearing;
   assign clearing = !clr_ff[MEM_ADDR_BITS];

   logic [2:0]               len_eff;
   logic [OFF_BITS-1:0]      off;
   logic [OFF_BITS:0]        room;
   logic [2:0]               first_n;
   logic [SET_BITS-1:0]      set_idx;
   logic [TAG_BITS-1:0]      tag_val;
   logic [BLK_BITS-1:0]      blk;
   logic                     any_hit;
   logic [WAY_BITS-1:0]      hit_way;
   logic                     any_free;
   logic [WAY_BITS-1:0]      free_way;
   logic [WAY_BITS-1:0]      rnd_way;
   logic [15:0]              lfsr_nx;
   logic [LINE_BITS-1:0]     line_idx;
   logic [OFF_BITS-1:0]      byte_off;
   logic [MEM_ADDR_BITS-1:0] mem_a;
   logic [7:0]               wbyte;
   logic [2:0]               pos;

   assign len_eff = (len_ff > 3'd4) ? 3'd4 : len_ff;
   assign off     = addr_ff[OFF_BITS-1:0];
   assign room    = (OFF_BITS + 1)'(sawtc_pkg::LINE_BYTES) - {1'b0, off};
   assign first_n = (room > {{(OFF_BITS - 2){1'b0}}, len_eff}) ? len_eff : room[2:0];

   // Set count and ways are powers of two, so set and tag are bit fields.
   assign blk     = paddr_ff[MEM_ADDR_BITS-1:OFF_BITS];
   assign set_idx = SET_BITS'(blk);
   assign tag_val = TAG_BITS'(blk >> SET_BITS);
   assign lfsr_nx = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign rnd_way = (WAYS > 1) ? lfsr_nx[WAY_BITS-1:0] : '0;

   always_comb begin
      any_hit  = 1'b0;
      hit_way  = '0;
      any_free = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (set_q_ff[w*ENTRY_BITS + TAG_BITS] &&
             set_q_ff[w*ENTRY_BITS +: TAG_BITS] == tag_val) begin
            any_hit = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!set_q_ff[w*ENTRY_BITS + TAG_BITS]) begin
            any_free = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   // The set word read for this part is updated with the new line's entry.
   always_comb begin
      set_wr = set_q_ff;
      set_wr[way_ff*ENTRY_BITS +: ENTRY_BITS] = {1'b1, tag_val};
   end

   assign line_idx = LINE_BITS'(set_idx * WAYS) + LINE_BITS'(way_ff);
   assign pos      = bidx_ff - pstart_ff;
   assign byte_off = ctl.fill_step ? fcnt_ff[OFF_BITS-1:0]
                                   : paddr_ff[OFF_BITS-1:0] + OFF_BITS'(pos);
   assign mem_a    = ctl.fill_step
                   ? {paddr_ff[MEM_ADDR_BITS-1:OFF_BITS], fcnt_ff[OFF_BITS-1:0]}
                   : paddr_ff + MEM_ADDR_BITS'(pos);
   assign wbyte    = wdata_ff[bidx_ff * 8 +: 8];

   // Tag and valid RAM, one word per set; registered read. Cleared with memory.
   always_ff @(posedge clock) begin
      if (clearing) begin
         set_mem[SET_BITS'(clr_ff)] <= '0;
      end else if (ctl.fill_done) begin
         set_mem[set_idx] <= set_wr;
      end
      if (ctl.tag_rd) begin
         set_q_ff <= set_mem[set_idx];
      end
   end

   // Line data RAM.
   always_ff @(posedge clock) begin
      if (ctl.fill_step && fcnt_ff != '0) begin
         data_mem[{line_idx, fcnt_ff[OFF_BITS-1:0] - 1'b1}] <= bk_q_ff;
      end else if (ctl.byte_op && cmd_ff && hit_ff && !rd_pend_ff) begin
         data_mem[{line_idx, byte_off}] <= wbyte;
      end
      data_q_ff <= data_mem[DATA_BITS'({line_idx, byte_off})];
   end

   // Backing memory; write port doubles as the clearing sweep.
   always_ff @(posedge clock) begin
      if (clearing) begin
         bk_mem[clr_ff[MEM_ADDR_BITS-1:0]] <= 8'h00;
      end else if (ctl.byte_op && cmd_ff && !rd_pend_ff) begin
         bk_mem[mem_a] <= wbyte;
      end
      bk_q_ff <= bk_mem[mem_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= sawtc_pkg::LFSR_SEED;
      end else if (ctl.resolve && !cmd_ff && !any_hit && !any_free) begin
         lfsr_ff <= lfsr_nx;
      end
   end

   // Fill, byte and part sequencing.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= req_tdata[0];
         addr_ff   <= MEM_ADDR_BITS'(req_tdata[20:1]);
         len_ff    <= req_tdata[23:21];
         wdata_ff  <= req_tdata[55:24];
         paddr_ff  <= MEM_ADDR_BITS'(req_tdata[20:1]);
         second_ff <= 1'b0;
         bidx_ff   <= '0;
         pstart_ff <= '0;
         rdata_ff  <= '0;
         hit1_ff   <= 1'b0;
         hit2_ff   <= 1'b0;
         span_ff   <= 1'b0;
      end
      if (ctl.tag_rd) begin
         pcnt_ff    <= second_ff ? len_eff - first_n : first_n;
         rd_pend_ff <= 1'b0;
      end
      if (ctl.resolve) begin
         hit_ff  <= any_hit;
         fcnt_ff <= '0;
         if (any_hit) begin
            way_ff <= hit_way;
         end else if (any_free) begin
            way_ff <= free_way;
         end else begin
            way_ff <= rnd_way;
         end
         if (second_ff) begin
            hit2_ff <= any_hit;
         end else begin
            hit1_ff <= any_hit;
         end
      end
      if (ctl.fill_step) begin
         fcnt_ff <= fcnt_ff + 1'b1;
      end
      if (ctl.byte_op) begin
         if (cmd_ff) begin
            bidx_ff <= bidx_ff + 1'b1;
         end else if (!rd_pend_ff) begin
            rd_pend_ff <= 1'b1;
            rd_idx_ff  <= bidx_ff;
         end else begin
            rdata_ff[rd_idx_ff * 8 +: 8] <= data_q_ff;
            rd_pend_ff <= 1'b0;
            bidx_ff    <= bidx_ff + 1'b1;
         end
      end
      if (ctl.part_setup) begin
         second_ff <= 1'b1;
         span_ff   <= 1'b1;
         pstart_ff <= first_n;
         paddr_ff  <= addr_ff + MEM_ADDR_BITS'(first_n);
      end
   end

   // The fill takes an extra step past the line's last byte: the memory read is registered.
   assign sts.fill_last  = fcnt_ff[OFF_BITS];
   assign sts.zero_len   = (len_ff == 3'd0);
   assign sts.is_write   = cmd_ff;
   assign sts.hit        = any_hit;
   assign sts.bytes_done = (cmd_ff || rd_pend_ff) && (pos + 3'd1 == pcnt_ff);
   assign sts.need_second = (len_eff > first_n);
   assign sts.on_second  = second_ff;
   assign sts.clear_done = !clearing;

   assign rsp_tdata = {5'b0, hit2_ff, span_ff, hit1_ff & (len_ff != 3'd0),
                       cmd_ff ? 32'h0 : rdata_ff};

endmodule

[rtl/set_assoc_write_through_cache.sv]
`timescale 1ns / 1ps

// Channel  Direction  tdata fields, low bit first
// req      in         command[0], address[20:1], length[23:21], write_data[55:24]
// rsp      out        read_data[31:0], first_hit[32], spans_two_lines[33], second_hit[34]
//
// One request at a time. After a request is accepted, each line part goes
// through a tag RAM read, a compare and a part step, plus its byte reads or
// writes; a byte read waits on the registered line data read. A read miss adds
// a line fill of LINE_BYTES bytes before the byte reads. After reset, backing
// memory and the tag RAM are cleared one word per cycle before the first
// request is taken. The response is held until rsp_tready. WAYS and NUM_LINES
// must be powers of two.
module set_assoc_write_through_cache #(
   parameter int WAYS          = 8,
   parameter int NUM_LINES     = 1024,
   parameter int MEM_ADDR_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // command, address, length, write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // read_data, first_hit, spans_two_lines, second_hit
);

   sawtc_pkg::ctl_type ctl;
   sawtc_pkg::sts_type sts;

   sawtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // The datapath reduces the address to the memory size when it loads it.
   sawtc_dp #(
      .WAYS          (WAYS),
      .NUM_LINES     (NUM_LINES),
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
